// ----- design/qrm_pkg.sv -----
// qrm_pkg: shared widths, types and rounding functions for the quaternion to
// rotation matrix unit. No dependencies.
`default_nettype none

package qrm_pkg;

    localparam int FRAC_BITS   = 14;
    localparam int COMP_WIDTH  = 16;
    localparam int QUAT_W      = 16;
    localparam int PROD_W      = 2 * QUAT_W;
    localparam int NUM_W       = PROD_W + 3;
    localparam int LEN_W       = PROD_W + 1;
    localparam int REM_W       = LEN_W + 1;
    localparam int QUO_W       = FRAC_BITS + 2;
    localparam int SAT_W       = ((QUO_W > COMP_WIDTH) ? QUO_W : COMP_WIDTH) + 1;
    localparam int ROT_N       = 3;
    localparam int NUM_ROWS    = 4;
    localparam int NUM_NUMS    = ROT_N * ROT_N;
    localparam int PIPE_STAGES = QUO_W + 1;
    localparam int MQ_DEPTH    = 4;
    localparam int MQ_AW       = $clog2(MQ_DEPTH);
    localparam int MQ_CW       = $clog2(MQ_DEPTH + 1);
    localparam int OF_DEPTH    = 32;
    localparam int OF_AW       = $clog2(OF_DEPTH);
    localparam int OF_CW       = $clog2(OF_DEPTH + 1);

    typedef logic [COMP_WIDTH-1:0]   elem_t;
    typedef logic [1:0]              col_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [NUM_W-1:0]  num_t;

    localparam col_t COL_FIRST = 2'd0;
    localparam col_t COL_LAST  = 2'd3;

    // numerators stored column-major: index = column * 3 + row
    typedef struct packed {
        logic [LEN_W-1:0]      len;
        num_t [NUM_NUMS-1:0]   num;
    } mid_item_t;

    typedef struct packed {
        elem_t [NUM_ROWS-1:0] elem;
        col_t                 col;
        logic                 last;
    } col_result_t;

    function automatic elem_t sat_elem(input logic neg, input logic [SAT_W-1:0] mag);
        logic [SAT_W-1:0] half;
        logic [SAT_W-1:0] lim;
        logic [SAT_W-1:0] m;
        half = SAT_W'(1) << (COMP_WIDTH - 1);
        lim  = neg ? half : (half - SAT_W'(1));
        m    = (mag > lim) ? lim : mag;
        return neg ? elem_t'(SAT_W'(0) - m) : elem_t'(m);
    endfunction

    // t = floor(2 * mag * 2^F / L); round half away is (t + 1) / 2
    function automatic elem_t round_elem(input logic neg, input logic [QUO_W-1:0] t);
        logic [QUO_W:0] tp;
        tp = {1'b0, t} + (QUO_W + 1)'(1);
        return sat_elem(neg, SAT_W'(tp >> 1));
    endfunction

    localparam elem_t ONE_ELEM = sat_elem(1'b0, SAT_W'(1) << FRAC_BITS);

endpackage

`default_nettype wire

// ----- design/qrm_front.sv -----
// qrm_front: takes quaternions, forms the ten products and then the length and
// the nine signed numerators. Depends on qrm_pkg.
`default_nettype none

module qrm_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire qrm_pkg::quat_t     quat_w,
    input  wire qrm_pkg::quat_t     quat_x,
    input  wire qrm_pkg::quat_t     quat_y,
    input  wire qrm_pkg::quat_t     quat_z,
    output logic                    item_valid,
    input  wire logic               item_ready,
    output qrm_pkg::mid_item_t      item
);
    import qrm_pkg::*;

    logic  prod_valid_reg;
    logic  prod_valid_next;
    logic  advance;
    prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    num_t  ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    num_t  len_sum;

    assign advance    = !prod_valid_reg || item_ready;
    assign full       = !advance;
    assign item_valid = prod_valid_reg;

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (advance)
        begin
            prod_valid_next = push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && push)
        begin
            ww_reg <= quat_w * quat_w;
            xx_reg <= quat_x * quat_x;
            yy_reg <= quat_y * quat_y;
            zz_reg <= quat_z * quat_z;
            xy_reg <= quat_x * quat_y;
            xz_reg <= quat_x * quat_z;
            yz_reg <= quat_y * quat_z;
            wx_reg <= quat_w * quat_x;
            wy_reg <= quat_w * quat_y;
            wz_reg <= quat_w * quat_z;
        end
    end

    always_comb
    begin
        ww = NUM_W'(ww_reg);
        xx = NUM_W'(xx_reg);
        yy = NUM_W'(yy_reg);
        zz = NUM_W'(zz_reg);
        xy = NUM_W'(xy_reg);
        xz = NUM_W'(xz_reg);
        yz = NUM_W'(yz_reg);
        wx = NUM_W'(wx_reg);
        wy = NUM_W'(wy_reg);
        wz = NUM_W'(wz_reg);
        len_sum     = ww + xx + yy + zz;
        item.len    = len_sum[LEN_W-1:0];
        item.num[0] = ww + xx - yy - zz;
        item.num[1] = (xy + wz) <<< 1;
        item.num[2] = (xz - wy) <<< 1;
        item.num[3] = (xy - wz) <<< 1;
        item.num[4] = ww - xx + yy - zz;
        item.num[5] = (yz + wx) <<< 1;
        item.num[6] = (xz + wy) <<< 1;
        item.num[7] = (yz - wx) <<< 1;
        item.num[8] = ww - xx - yy + zz;
    end

endmodule

`default_nettype wire

// ----- design/qrm_mid_queue.sv -----
// qrm_mid_queue: short queue of prepared quaternion items between the front
// and the back. Depends on qrm_pkg.
`default_nettype none

module qrm_mid_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire qrm_pkg::mid_item_t  in_item,
    output logic                     out_valid,
    input  wire logic                out_pop,
    output qrm_pkg::mid_item_t       out_item
);
    import qrm_pkg::*;

    mid_item_t          slot_reg [MQ_DEPTH];
    logic [MQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [MQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [MQ_CW-1:0]   count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    assign in_ready  = (count_reg != MQ_CW'(MQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign wr_en     = in_valid && in_ready;
    assign rd_en     = out_pop && out_valid;
    assign out_item  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + MQ_AW'(wr_en);
        rd_ptr_next = rd_ptr_reg + MQ_AW'(rd_en);
        count_next  = count_reg + MQ_CW'(wr_en) - MQ_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- design/qrm_back.sv -----
// qrm_back: given an item and result queue room, issues one column per cycle
// into three restoring-division lanes, rounds and queues it. Depends on qrm_pkg.
`default_nettype none

module qrm_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_pop,
    input  wire qrm_pkg::mid_item_t  item,
    output logic                     empty,
    input  wire logic                pop,
    output qrm_pkg::col_result_t     result
);
    import qrm_pkg::*;

    col_t               col_reg, col_next;
    logic               issue;
    logic               credit_ok;
    logic [OF_CW:0]     occupancy;
    logic [OF_CW-1:0]   inflight_reg, inflight_next;

    logic [REM_W-1:0]   rem_reg  [PIPE_STAGES][ROT_N];
    logic [REM_W-1:0]   rem_next [PIPE_STAGES][ROT_N];
    logic [QUO_W-1:0]   quo_reg  [PIPE_STAGES][ROT_N];
    logic [QUO_W-1:0]   quo_next [PIPE_STAGES][ROT_N];
    logic               neg_reg  [PIPE_STAGES][ROT_N];
    logic               neg_next [PIPE_STAGES][ROT_N];
    logic [LEN_W-1:0]   len_reg  [PIPE_STAGES];
    logic [LEN_W-1:0]   len_next [PIPE_STAGES];
    col_t               scol_reg [PIPE_STAGES];
    col_t               scol_next[PIPE_STAGES];
    logic               fixed_reg [PIPE_STAGES];
    logic               fixed_next[PIPE_STAGES];
    logic               valid_reg [PIPE_STAGES];
    logic               valid_next[PIPE_STAGES];

    col_result_t        fifo_reg [OF_DEPTH];
    col_result_t        wr_entry;
    logic [OF_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OF_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OF_CW-1:0]   count_reg, count_next;
    logic               wr_en;
    logic               rd_en;

    // every issued column has a slot reserved in the result queue
    assign occupancy = {1'b0, count_reg} + {1'b0, inflight_reg};
    assign credit_ok = (occupancy < (OF_CW + 1)'(OF_DEPTH));
    assign issue     = item_valid && credit_ok;
    assign item_pop  = issue && (col_reg == COL_LAST);
    assign col_next  = issue ? (col_reg + 2'd1) : col_reg;

    assign wr_en  = valid_reg[PIPE_STAGES-1];
    assign rd_en  = pop && !empty;
    assign empty  = (count_reg == '0);
    assign result = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        num_t             n;
        logic [NUM_W-1:0] mag;
        logic [REM_W-1:0] sh;
        logic             ge;
        // issue stage: pick this column's numerators, take magnitudes
        for (int r = 0; r < ROT_N; r++)
        begin
            n = num_t'(0);
            unique case (col_reg)
                2'd0:    n = $signed(item.num[r]);
                2'd1:    n = $signed(item.num[ROT_N + r]);
                2'd2:    n = $signed(item.num[2 * ROT_N + r]);
                default: n = num_t'(0);
            endcase
            mag = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
            rem_next[0][r] = mag[REM_W-1:0];
            quo_next[0][r] = '0;
            neg_next[0][r] = n[NUM_W-1];
        end
        len_next[0]   = item.len;
        scol_next[0]  = col_reg;
        fixed_next[0] = (col_reg == COL_LAST) || (item.len == '0);
        valid_next[0] = issue;
        // one quotient bit per stage; the first bit has weight 2^(F+1), no shift
        for (int s = 1; s < PIPE_STAGES; s++)
        begin
            for (int r = 0; r < ROT_N; r++)
            begin
                sh = (s == 1) ? rem_reg[s-1][r] : (rem_reg[s-1][r] << 1);
                ge = (sh >= {1'b0, len_reg[s-1]});
                rem_next[s][r] = ge ? (sh - {1'b0, len_reg[s-1]}) : sh;
                quo_next[s][r] = {quo_reg[s-1][r][QUO_W-2:0], ge};
                neg_next[s][r] = neg_reg[s-1][r];
            end
            len_next[s]   = len_reg[s-1];
            scol_next[s]  = scol_reg[s-1];
            fixed_next[s] = fixed_reg[s-1];
            valid_next[s] = valid_reg[s-1];
        end
    end

    always_comb
    begin
        for (int r = 0; r < ROT_N; r++)
        begin
            if (fixed_reg[PIPE_STAGES-1])
            begin
                wr_entry.elem[r] = (scol_reg[PIPE_STAGES-1] == col_t'(r)) ? ONE_ELEM : '0;
            end
            else
            begin
                wr_entry.elem[r] = round_elem(neg_reg[PIPE_STAGES-1][r],
                                              quo_reg[PIPE_STAGES-1][r]);
            end
        end
        wr_entry.elem[ROT_N] = (scol_reg[PIPE_STAGES-1] == COL_LAST) ? ONE_ELEM : '0;
        wr_entry.col         = scol_reg[PIPE_STAGES-1];
        wr_entry.last        = (scol_reg[PIPE_STAGES-1] == COL_LAST);
    end

    always_comb
    begin
        inflight_next = inflight_reg + OF_CW'(issue) - OF_CW'(wr_en);
        wr_ptr_next   = wr_ptr_reg + OF_AW'(wr_en);
        rd_ptr_next   = rd_ptr_reg + OF_AW'(rd_en);
        count_next    = count_reg + OF_CW'(wr_en) - OF_CW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= COL_FIRST;
            inflight_reg <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            col_reg      <= col_next;
            inflight_reg <= inflight_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            for (int s = 0; s < PIPE_STAGES; s++)
            begin
                valid_reg[s] <= valid_next[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < PIPE_STAGES; s++)
        begin
            for (int r = 0; r < ROT_N; r++)
            begin
                rem_reg[s][r] <= rem_next[s][r];
                quo_reg[s][r] <= quo_next[s][r];
                neg_reg[s][r] <= neg_next[s][r];
            end
            len_reg[s]   <= len_next[s];
            scol_reg[s]  <= scol_next[s];
            fixed_reg[s] <= fixed_next[s];
        end
        if (wr_en)
        begin
            fifo_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

`default_nettype wire

// ----- design/quaternion_to_rotation_matrix_unit.sv -----
// quaternion_to_rotation_matrix_unit: top level joining front, mid queue and
// back. Depends on qrm_pkg, qrm_front, qrm_mid_queue, qrm_back.
// Each quaternion yields four column results of the 4x4 column-major rotation
// matrix in Q1.14, column 0 first, last_column set on column 3; elements are
// the exact ratios over w^2+x^2+y^2+z^2 rounded half away from zero, and a
// zero quaternion gives the identity. Columns are issued one per cycle into
// the three division lanes while an item waits and the result queue has room;
// a result passes the product register, the mid queue, the issue stage, the
// 16-step restoring division pipeline and the result queue.
`default_nettype none

module quaternion_to_rotation_matrix_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire qrm_pkg::quat_t   quat_w,
    input  wire qrm_pkg::quat_t   quat_x,
    input  wire qrm_pkg::quat_t   quat_y,
    input  wire qrm_pkg::quat_t   quat_z,
    output logic                  empty,
    input  wire logic             pop,
    output qrm_pkg::elem_t        elem_row0,
    output qrm_pkg::elem_t        elem_row1,
    output qrm_pkg::elem_t        elem_row2,
    output qrm_pkg::elem_t        elem_row3,
    output qrm_pkg::col_t         column_index,
    output logic                  last_column
);
    import qrm_pkg::*;

    logic        fr_valid;
    logic        fr_ready;
    mid_item_t   fr_item;
    logic        mq_valid;
    logic        mq_pop;
    mid_item_t   mq_item;
    col_result_t res;

    qrm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .item_valid (fr_valid),
        .item_ready (fr_ready),
        .item       (fr_item)
    );

    qrm_mid_queue u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (mq_valid),
        .out_pop   (mq_pop),
        .out_item  (mq_item)
    );

    qrm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (mq_valid),
        .item_pop   (mq_pop),
        .item       (mq_item),
        .empty      (empty),
        .pop        (pop),
        .result     (res)
    );

    assign elem_row0    = res.elem[0];
    assign elem_row1    = res.elem[1];
    assign elem_row2    = res.elem[2];
    assign elem_row3    = res.elem[3];
    assign column_index = res.col;
    assign last_column  = res.last;

    // the last flag marks column 3 only
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_column == (column_index == COL_LAST)))
        else $error("last_column does not match column_index");

    // bottom row is zero except on the last column
    a_row3_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (column_index != COL_LAST)) |-> (elem_row3 == '0))
        else $error("row 3 nonzero outside column 3");

    // after a column that is not the last one, the next result is the next column
    a_col_order: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last_column) |=>
            (empty || (column_index == $past(column_index) + 2'd1)))
        else $error("column results out of order");

endmodule

`default_nettype wire

// ----- tb/tb_quaternion_to_rotation_matrix_unit.sv -----
// testbench for quaternion_to_rotation_matrix_unit: random and directed quaternions,
// columns checked against an in-bench fixed-point rotation matrix predictor.
// Depends on qrm_pkg and the rtl of the unit.
`timescale 1ns / 1ps

module tb_quaternion_to_rotation_matrix_unit;

    import qrm_pkg::*;

    typedef struct {
        quat_t w;
        quat_t x;
        quat_t y;
        quat_t z;
    } quat_item_t;

    typedef struct {
        elem_t r0;
        elem_t r1;
        elem_t r2;
        elem_t r3;
        col_t  col;
        logic  last;
    } column_t;

    localparam int CYCLE_LIMIT = 400000;

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  push = 1'b0;
    logic  pop = 1'b0;
    quat_t quat_w = '0;
    quat_t quat_x = '0;
    quat_t quat_y = '0;
    quat_t quat_z = '0;
    logic  full;
    logic  empty;
    elem_t elem_row0;
    elem_t elem_row1;
    elem_t elem_row2;
    elem_t elem_row3;
    col_t  column_index;
    logic  last_column;

    quat_item_t pending_quats[$];
    column_t    expected_columns[$];
    int         mismatches = 0;
    int         cycles = 0;
    int         hold_pop_cycles = 0;
    bit         stimulus_done = 0;
    bit         sender_paused = 0;
    bit         steady_phase = 0;
    bit         in_accepted = 0;

    quaternion_to_rotation_matrix_unit dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .empty(empty), .pop(pop),
        .elem_row0(elem_row0), .elem_row1(elem_row1), .elem_row2(elem_row2),
        .elem_row3(elem_row3), .column_index(column_index), .last_column(last_column)
    );

    always #10 clk = ~clk;

    // round(num * 2^14 / len), ties away from zero, saturated to 16 bits
    function automatic elem_t rotation_ratio(longint num, longint len);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * (mag <<< FRAC_BITS) + len) / (2 * len);
        if (num < 0)
        begin
            if (q > 32768)
                q = 32768;
            return elem_t'(-q);
        end
        if (q > 32767)
            q = 32767;
        return elem_t'(q);
    endfunction

    task automatic predict_matrix(quat_item_t q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint len;
        elem_t  m[16];
        column_t c;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        len = w*w + x*x + y*y + z*z;
        foreach (m[i])
            m[i] = '0;
        if (len == 0)
        begin
            m[0] = elem_t'(1 << FRAC_BITS);
            m[5] = elem_t'(1 << FRAC_BITS);
            m[10] = elem_t'(1 << FRAC_BITS);
        end
        else
        begin
            m[0] = rotation_ratio(w*w + x*x - y*y - z*z, len);
            m[1] = rotation_ratio(2 * (x*y + w*z), len);
            m[2] = rotation_ratio(2 * (x*z - w*y), len);
            m[4] = rotation_ratio(2 * (x*y - w*z), len);
            m[5] = rotation_ratio(w*w - x*x + y*y - z*z, len);
            m[6] = rotation_ratio(2 * (y*z + w*x), len);
            m[8] = rotation_ratio(2 * (x*z + w*y), len);
            m[9] = rotation_ratio(2 * (y*z - w*x), len);
            m[10] = rotation_ratio(w*w - x*x - y*y + z*z, len);
        end
        m[15] = elem_t'(1 << FRAC_BITS);
        for (int k = 0; k < 4; k++)
        begin
            c.r0 = m[k*4];
            c.r1 = m[k*4 + 1];
            c.r2 = m[k*4 + 2];
            c.r3 = m[k*4 + 3];
            c.col = col_t'(k);
            c.last = (k == 3);
            expected_columns.push_back(c);
        end
    endtask

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d", what, got, want);
    endtask

    function automatic quat_t rand_comp();
        case ($urandom_range(0, 9))
            0: return quat_t'(16'sh8000);
            1: return quat_t'(16'sh7fff);
            2: return '0;
            3: return quat_t'($urandom_range(0, 15)) - quat_t'(8);
            default: return quat_t'($urandom);
        endcase
    endfunction

    task automatic add_quat(int w, int x, int y, int z);
        quat_item_t q;
        q.w = quat_t'(w);
        q.x = quat_t'(x);
        q.y = quat_t'(y);
        q.z = quat_t'(z);
        pending_quats.push_back(q);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        quat_item_t q;
        if (rst_n)
        begin
            // transfer seen at the last rising edge
            if (in_accepted)
                void'(pending_quats.pop_front());
            if (pending_quats.size() > 0 && !sender_paused &&
                (steady_phase || $urandom_range(0, 99) >= 34))
            begin
                q = pending_quats[0];
                push <= 1'b1;
                quat_w <= q.w;
                quat_x <= q.x;
                quat_y <= q.y;
                quat_z <= q.z;
            end
            else
                push <= 1'b0;
        end
    end

    // predictor fed at the accepting edge
    always @(posedge clk)
    begin
        quat_item_t q;
        in_accepted <= rst_n && push && !full;
        if (rst_n && push && !full)
        begin
            q.w = quat_w;
            q.x = quat_x;
            q.y = quat_y;
            q.z = quat_z;
            predict_matrix(q);
        end
    end

    // receiver: pop decided at the falling edge
    always @(negedge clk)
    begin
        if (hold_pop_cycles > 0)
        begin
            hold_pop_cycles <= hold_pop_cycles - 1;
            pop <= 1'b0;
        end
        else
            pop <= steady_phase || ($urandom_range(0, 99) >= 34);
    end

    // monitor: check each column transfer against the oldest expectation
    always @(posedge clk)
    begin
        column_t e;
        cycles <= cycles + 1;
        if (rst_n && pop && !empty)
        begin
            if (expected_columns.size() == 0)
                report_mismatch("unexpected column", column_index, -1);
            else
            begin
                e = expected_columns.pop_front();
                if (elem_row0 !== e.r0)
                    report_mismatch("elem_row0", $signed(elem_row0), $signed(e.r0));
                if (elem_row1 !== e.r1)
                    report_mismatch("elem_row1", $signed(elem_row1), $signed(e.r1));
                if (elem_row2 !== e.r2)
                    report_mismatch("elem_row2", $signed(elem_row2), $signed(e.r2));
                if (elem_row3 !== e.r3)
                    report_mismatch("elem_row3", $signed(elem_row3), $signed(e.r3));
                if (column_index !== e.col)
                    report_mismatch("column_index", column_index, e.col);
                if (last_column !== e.last)
                    report_mismatch("last_column", last_column, e.last);
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_quaternion_to_rotation_matrix_unit: FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: zero, identity, axis flips, extremes, ties
        add_quat(0, 0, 0, 0);
        add_quat(1, 0, 0, 0);
        add_quat(-1, 0, 0, 0);
        add_quat(0, 1, 0, 0);
        add_quat(0, 0, 1, 0);
        add_quat(0, 0, 0, 1);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, -32768, 0, 0);
        add_quat(0, 0, -32768, 32767);
        add_quat(1, 1, 0, 0);
        add_quat(1, 1, 1, 1);
        add_quat(3, 1, 1, 1);
        add_quat(1, 2, 3, 4);
        add_quat(-5, 7, -11, 13);
        add_quat(0, -32768, 0, 0);
        add_quat(21845, -21846, 10922, -1);
        add_quat(-1, -1, -1, -1);
        add_quat(1, 0, 0, -32768);

        // back-pressure: receiver holds off while sender keeps offering
        for (int i = 0; i < 40; i++)
            add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        hold_pop_cycles <= 300;
        wait (pending_quats.size() == 0 && hold_pop_cycles == 0);

        // sender pauses until everything has drained
        sender_paused = 1;
        wait (expected_columns.size() == 0);
        sender_paused = 0;

        // steady stretch with no idling on either side
        steady_phase = 1;
        for (int i = 0; i < 80; i++)
            add_quat($urandom, $urandom, $urandom, $urandom);
        wait (pending_quats.size() == 0);
        steady_phase = 0;

        for (int i = 0; i < 290; i++)
            add_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        wait (pending_quats.size() == 0);
        stimulus_done = 1;
        wait (expected_columns.size() == 0);
        repeat (40) @(posedge clk);

        if (mismatches == 0)
            $display("tb_quaternion_to_rotation_matrix_unit: PASS");
        else
            $display("tb_quaternion_to_rotation_matrix_unit: FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/qrm_pkg.sv
design/qrm_front.sv
design/qrm_mid_queue.sv
design/qrm_back.sv
design/quaternion_to_rotation_matrix_unit.sv
tb/tb_quaternion_to_rotation_matrix_unit.sv
